/* sv/ewld_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ewld_pkg;

   // Width of every sample and register field on the ports.
   localparam int FieldBits = 12;

   // Configuration register indexes.
   localparam int CsrIndexBits = 3;
   localparam logic [CsrIndexBits-1:0] CSR_BASELINE_FIRST  = 3'd0;
   localparam logic [CsrIndexBits-1:0] CSR_BASELINE_SECOND = 3'd1;
   localparam logic [CsrIndexBits-1:0] CSR_OPEN_THRESHOLD  = 3'd2;
   localparam logic [CsrIndexBits-1:0] CSR_CLOSE_THRESHOLD = 3'd3;
   localparam logic [CsrIndexBits-1:0] CSR_FORCE_THRESHOLD = 3'd4;

   // Request kinds carried in tuser.
   localparam logic OP_FULL        = 1'b0;
   localparam logic OP_CALIBRATION = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_DONE
   } ewld_state_type;

   // Controls from the sequencer to the per-channel mean units.
   typedef struct packed {
      logic clear;
      logic accumulate;
      logic load;
   } ewld_ctl_type;

endpackage

`default_nettype wire

/* sv/ewld_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One window slot for both channels; passes its entry to the next slot on shift.
module ewld_cell #(
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        shift_en,
   input  wire logic [1:0][SAMPLE_BITS-1:0] d_in,
   output logic      [1:0][SAMPLE_BITS-1:0] q_out
);

   logic [1:0][SAMPLE_BITS-1:0] entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift_en) begin
         entry_ff <= d_in;
      end
   end

   assign q_out = entry_ff;

endmodule

`default_nettype wire

/* sv/ewld_mean.sv */
`timescale 1ns / 1ps
`default_nettype none

// Accumulates |entry - base| as the window streams past, then divides by the window size.
module ewld_mean import ewld_pkg::*; #(
   parameter int WINDOW_SIZE = 32,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                   clock,
   input  wire ewld_ctl_type           ctl,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   input  wire logic [SAMPLE_BITS-1:0] base,
   output logic      [SAMPLE_BITS-1:0] level
);

   localparam int WinBits = $clog2(WINDOW_SIZE);
   localparam int SumBits = SAMPLE_BITS + WinBits;
   localparam bit WinPow2 = (WINDOW_SIZE & (WINDOW_SIZE - 1)) == 0;

   logic [SAMPLE_BITS-1:0] diff;
   logic [SumBits-1:0]     sum_ff;
   logic [SumBits-1:0]     sum_in;

   assign diff = (sample >= base) ? (sample - base) : (base - sample);

   always_comb begin
      sum_in = sum_ff;
      if (ctl.clear) begin
         sum_in = '0;
      end else if (ctl.accumulate) begin
         sum_in = sum_ff + SumBits'(diff);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   generate
      if (WinPow2) begin : g_shift
         assign level = sum_ff[SumBits-1:WinBits];
      end else begin : g_divide
         // Division by the constant window size through its rounded-up reciprocal.
         // With the shift set to the sum width plus the divisor's bit count, the
         // truncated product equals the quotient for every sum the window can hold.
         localparam int     RecipShift = SumBits + WinBits;
         localparam int     RecipBits  = SumBits + 1;
         localparam int     ProdBits   = SumBits + RecipBits;
         localparam longint RecipValue =
            ((longint'(1) << RecipShift) + longint'(WINDOW_SIZE) - 1) / longint'(WINDOW_SIZE);

         logic [RecipBits-1:0]   recip;
         logic [ProdBits-1:0]    product;
         logic [SAMPLE_BITS-1:0] quo_ff;
         logic [SAMPLE_BITS-1:0] quo_in;

         assign recip   = RecipBits'(RecipValue);
         assign product = ProdBits'(sum_ff) * ProdBits'(recip);

         always_comb begin
            quo_in = quo_ff;
            if (ctl.load) begin
               quo_in = product[RecipShift +: SAMPLE_BITS];
            end
         end

         always_ff @(posedge clock) begin
            quo_ff <= quo_in;
         end

         assign level = quo_ff;
      end
   endgenerate

endmodule

`default_nettype wire

/* sv/emg_window_level_detector_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// rsp_tvalid rises once the cell chain has rotated through all its cells past the
// accumulators, after a registered divide when WINDOW_SIZE is not a power of two.
// A new request is taken only after the response for the last one is registered, and
// an earlier response still waiting to be taken holds the block in its done state.
// Reset: synchronous; all window cells, held levels, forces and flags clear, and the
// registers take their documented reset values.
module emg_window_level_detector_top import ewld_pkg::*; #(
   parameter int WINDOW_SIZE = 32,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Request channel.
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // From bit 0: emg_first[11:0], emg_second[23:12], force_first[35:24],
   // force_second[47:36].
   input  wire logic [47:0]             req_tdata,
   // From bit 0: op.
   input  wire logic [0:0]              req_tuser,
   // Response channel.
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // From bit 0: level_first[11:0], level_second[23:12], force_value_first[35:24],
   // force_value_second[47:36], pressed_first[48], pressed_second[49],
   // open_flag[50], close_flag[51], zero fill[55:52].
   output logic [55:0]                  rsp_tdata,
   // Configuration write channel.
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CsrIndexBits-1:0] csr_index,
   input  wire logic [FieldBits-1:0]    csr_wdata
);

   localparam int  WinBits  = $clog2(WINDOW_SIZE);
   localparam int  CntBits  = WinBits;
   localparam bit  WinPow2  = (WINDOW_SIZE & (WINDOW_SIZE - 1)) == 0;

   // ---------------------------------------------------------------------------------
   // Configuration registers. Values are held at the sample width; the port is always
   // ready, and writes to unknown indexes are dropped.
   // ---------------------------------------------------------------------------------
   logic [SAMPLE_BITS-1:0] baseline_first_ff;
   logic [SAMPLE_BITS-1:0] baseline_second_ff;
   logic [SAMPLE_BITS-1:0] open_threshold_ff;
   logic [SAMPLE_BITS-1:0] close_threshold_ff;
   logic [SAMPLE_BITS-1:0] force_threshold_ff;
   logic [SAMPLE_BITS-1:0] csr_value;

   assign csr_ready = 1'b1;
   assign csr_value = SAMPLE_BITS'(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_first_ff  <= '0;
         baseline_second_ff <= '0;
         open_threshold_ff  <= SAMPLE_BITS'(12'd4095);
         close_threshold_ff <= SAMPLE_BITS'(12'd4095);
         force_threshold_ff <= SAMPLE_BITS'(12'd512);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASELINE_FIRST:  baseline_first_ff  <= csr_value;
            CSR_BASELINE_SECOND: baseline_second_ff <= csr_value;
            CSR_OPEN_THRESHOLD:  open_threshold_ff  <= csr_value;
            CSR_CLOSE_THRESHOLD: close_threshold_ff <= csr_value;
            CSR_FORCE_THRESHOLD: force_threshold_ff <= csr_value;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Request capture. The EMG samples go straight into the head of the cell chain;
   // the kind and force samples wait here until the result is formed.
   // ---------------------------------------------------------------------------------
   logic                   req_accept;
   logic [SAMPLE_BITS-1:0] emg_first_s;
   logic [SAMPLE_BITS-1:0] emg_second_s;
   logic                   op_ff;
   logic [SAMPLE_BITS-1:0] force_first_ff;
   logic [SAMPLE_BITS-1:0] force_second_ff;

   assign req_accept   = req_tvalid && req_tready;
   assign emg_first_s  = SAMPLE_BITS'(req_tdata[11:0]);
   assign emg_second_s = SAMPLE_BITS'(req_tdata[23:12]);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff           <= req_tuser[0];
         force_first_ff  <= SAMPLE_BITS'(req_tdata[35:24]);
         force_second_ff <= SAMPLE_BITS'(req_tdata[47:36]);
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencer. An accepted request shifts the new samples into the chain, dropping the
   // oldest entry. The chain then rotates once through all its cells, and each entry
   // passes the accumulators at the tail. Only the set of entries matters to the mean,
   // so no write pointer is needed.
   // ---------------------------------------------------------------------------------
   ewld_state_type      state_ff;
   ewld_state_type      state_in;
   logic [CntBits-1:0]  cnt_ff;
   logic [CntBits-1:0]  cnt_in;
   ewld_ctl_type        ctl;
   logic                rotate;
   logic                finish;
   logic                rsp_valid_ff;
   logic                rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      ctl            = '0;
      rotate         = 1'b0;
      finish         = 1'b0;
      req_tready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.clear = 1'b1;
               cnt_in    = '0;
               state_in  = ST_SUM;
            end
         end
         ST_SUM: begin
            rotate         = 1'b1;
            ctl.accumulate = 1'b1;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == CntBits'(WINDOW_SIZE - 1)) begin
               cnt_in   = '0;
               state_in = WinPow2 ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            // Loads the reciprocal-multiply quotient when the size is not a power of two.
            ctl.load = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Cell chain: channel 0 is the first EMG input, channel 1 the second.
   // ---------------------------------------------------------------------------------
   logic [WINDOW_SIZE-1:0][1:0][SAMPLE_BITS-1:0] cell_q;
   logic [WINDOW_SIZE-1:0][1:0][SAMPLE_BITS-1:0] cell_d;
   logic                                         shift_en;

   assign shift_en  = req_accept || rotate;
   assign cell_d[0] = rotate ? cell_q[WINDOW_SIZE-1] : {emg_second_s, emg_first_s};

   genvar gi;
   generate
      for (gi = 1; gi < WINDOW_SIZE; gi++) begin : g_link
         assign cell_d[gi] = cell_q[gi-1];
      end
      for (gi = 0; gi < WINDOW_SIZE; gi++) begin : g_cell
         ewld_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift_en(shift_en),
            .d_in    (cell_d[gi]),
            .q_out   (cell_q[gi])
         );
      end
   endgenerate

   // ---------------------------------------------------------------------------------
   // Per-channel mean of the absolute deviation from the baseline.
   // ---------------------------------------------------------------------------------
   logic [SAMPLE_BITS-1:0] level_first;
   logic [SAMPLE_BITS-1:0] level_second;

   ewld_mean #(
      .WINDOW_SIZE(WINDOW_SIZE),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_mean_first (
      .clock (clock),
      .ctl   (ctl),
      .sample(cell_q[WINDOW_SIZE-1][0]),
      .base  (baseline_first_ff),
      .level (level_first)
   );

   ewld_mean #(
      .WINDOW_SIZE(WINDOW_SIZE),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_mean_second (
      .clock (clock),
      .ctl   (ctl),
      .sample(cell_q[WINDOW_SIZE-1][1]),
      .base  (baseline_second_ff),
      .level (level_second)
   );

   // ---------------------------------------------------------------------------------
   // Response register. It also holds the levels, forces and flags between requests: a
   // calibration request refreshes only the levels, so the rest carries over.
   // ---------------------------------------------------------------------------------
   logic [FieldBits-1:0] level_first_ff;
   logic [FieldBits-1:0] level_second_ff;
   logic [FieldBits-1:0] force_value_first_ff;
   logic [FieldBits-1:0] force_value_second_ff;
   logic                 pressed_first_ff;
   logic                 pressed_second_ff;
   logic                 open_flag_ff;
   logic                 close_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff          <= 1'b0;
         level_first_ff        <= '0;
         level_second_ff       <= '0;
         force_value_first_ff  <= '0;
         force_value_second_ff <= '0;
         pressed_first_ff      <= 1'b0;
         pressed_second_ff     <= 1'b0;
         open_flag_ff          <= 1'b0;
         close_flag_ff         <= 1'b0;
      end else begin
         if (finish) begin
            rsp_valid_ff    <= 1'b1;
            level_first_ff  <= FieldBits'(level_first);
            level_second_ff <= FieldBits'(level_second);
            if (op_ff == OP_FULL) begin
               force_value_first_ff  <= FieldBits'(force_first_ff);
               force_value_second_ff <= FieldBits'(force_second_ff);
               pressed_first_ff      <= force_first_ff > force_threshold_ff;
               pressed_second_ff     <= force_second_ff > force_threshold_ff;
               open_flag_ff          <= level_first > open_threshold_ff;
               close_flag_ff         <= level_second > close_threshold_ff;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, close_flag_ff, open_flag_ff, pressed_second_ff,
                        pressed_first_ff, force_value_second_ff, force_value_first_ff,
                        level_second_ff, level_first_ff};

endmodule

`default_nettype wire

/* sv/ewld_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ewld_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);

   // A waiting response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response withdrawn while stalled");

   // A waiting response keeps its data.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   // One request at a time: the block is busy right after taking a request.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is in progress");

   // A new response only appears at the end of a request's work.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response raised while the block was idle");

endmodule

bind emg_window_level_detector_top ewld_checker u_ewld_checker (.*);

`default_nettype wire

/* tb/emg_window_level_detector_top_test.sv */
`timescale 1ns / 1ps

module emg_window_level_detector_top_test;
   import ewld_pkg::*;

   // The response needs one full pass of the window past the accumulators.
   localparam int RESPONSE_LATENCY = 34;
   // How long the response side holds off once, so that the block backs up.
   localparam int LONG_HOLD_CYCLES = 300;
   // Hard limit on the whole run, far beyond the slowest correct run.
   localparam int RUN_LIMIT_NS = 2_000_000;
   localparam logic [FieldBits-1:0] FIELD_MAX = '1;

   // One response as it sits in rsp_tdata, level_first in the lowest bits.
   typedef struct packed {
      logic                 close_flag;
      logic                 open_flag;
      logic                 pressed_second;
      logic                 pressed_first;
      logic [FieldBits-1:0] force_value_second;
      logic [FieldBits-1:0] force_value_first;
      logic [FieldBits-1:0] level_second;
      logic [FieldBits-1:0] level_first;
   } detector_status_t;

   // Tracks the detector state on the side of the test. Each accepted request
   // updates the windows and held values and queues the response it causes;
   // each accepted response is checked against the oldest queued one.
   class level_tracker;
      localparam int WindowLen = 32;

      logic [FieldBits-1:0] window_first [WindowLen];
      logic [FieldBits-1:0] window_second [WindowLen];
      int unsigned          write_pos;
      logic [FieldBits-1:0] base_first;
      logic [FieldBits-1:0] base_second;
      logic [FieldBits-1:0] open_limit;
      logic [FieldBits-1:0] close_limit;
      logic [FieldBits-1:0] force_limit;
      detector_status_t     held;
      detector_status_t     pending_status [$];
      int                   mismatches;

      function new();
         foreach (window_first[k]) begin
            window_first[k] = '0;
            window_second[k] = '0;
         end
         write_pos = 0;
         base_first = '0;
         base_second = '0;
         open_limit = FIELD_MAX;
         close_limit = FIELD_MAX;
         force_limit = FieldBits'(512);
         held = '0;
         mismatches = 0;
      endfunction

      function void write_register(logic [CsrIndexBits-1:0] index, logic [FieldBits-1:0] value);
         case (index)
            CSR_BASELINE_FIRST:  base_first = value;
            CSR_BASELINE_SECOND: base_second = value;
            CSR_OPEN_THRESHOLD:  open_limit = value;
            CSR_CLOSE_THRESHOLD: close_limit = value;
            CSR_FORCE_THRESHOLD: force_limit = value;
            default: ;
         endcase
      endfunction

      // Truncated mean of |cell - base| over the whole window.
      function logic [FieldBits-1:0] mean_deviation(input logic [FieldBits-1:0] cells [WindowLen],
                                                    input logic [FieldBits-1:0] base);
         int unsigned total;
         total = 0;
         foreach (cells[k])
            total += (cells[k] >= base) ? int'(cells[k]) - int'(base) : int'(base) - int'(cells[k]);
         return FieldBits'(total / WindowLen);
      endfunction

      function void note_sample(logic op, logic [FieldBits-1:0] emg_a, logic [FieldBits-1:0] emg_b,
                                logic [FieldBits-1:0] force_a, logic [FieldBits-1:0] force_b);
         window_first[write_pos] = emg_a;
         window_second[write_pos] = emg_b;
         write_pos = (write_pos + 1) % WindowLen;
         held.level_first = mean_deviation(window_first, base_first);
         held.level_second = mean_deviation(window_second, base_second);
         // A calibration request leaves forces and all flags as they were.
         if (op == OP_FULL) begin
            held.force_value_first = force_a;
            held.force_value_second = force_b;
            held.pressed_first = force_a > force_limit;
            held.pressed_second = force_b > force_limit;
            held.open_flag = held.level_first > open_limit;
            held.close_flag = held.level_second > close_limit;
         end
         pending_status.push_back(held);
      endfunction

      task report_mismatch(string text);
         mismatches++;
         $display("MISMATCH at %0t ns: %s", $time, text);
      endtask

      task compare_field(string name, int unsigned got, int unsigned want);
         if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      endtask

      task check_status(logic [55:0] data);
         detector_status_t got;
         detector_status_t want;
         got = data[51:0];
         if (pending_status.size() == 0) begin
            report_mismatch($sformatf("response %h with no request outstanding", data));
            return;
         end
         want = pending_status.pop_front();
         compare_field("level_first", got.level_first, want.level_first);
         compare_field("level_second", got.level_second, want.level_second);
         compare_field("force_value_first", got.force_value_first, want.force_value_first);
         compare_field("force_value_second", got.force_value_second, want.force_value_second);
         compare_field("pressed_first", got.pressed_first, want.pressed_first);
         compare_field("pressed_second", got.pressed_second, want.pressed_second);
         compare_field("open_flag", got.open_flag, want.open_flag);
         compare_field("close_flag", got.close_flag, want.close_flag);
         compare_field("zero fill", data[55:52], 0);
      endtask
   endclass

   // All inputs of the block start from known values.
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [47:0]             req_tdata = '0;
   logic [0:0]              req_tuser = OP_FULL;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [55:0]             rsp_tdata;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [FieldBits-1:0]    csr_wdata = '0;

   // Shared between the request and response processes: a burst stretch turns
   // idling off on both sides, and a hold request asks the response side for
   // one long stall.
   bit burst_mode = 1'b0;
   bit hold_request = 1'b0;

   level_tracker board;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   emg_window_level_detector_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Offers one request and returns at the rising edge that accepts it.
   // Handshake inputs are looked at on the falling edge, where they are
   // stable, so the outcome never hinges on event order at the rising edge.
   // A valid that stays high between back-to-back requests is never lowered.
   task automatic send_sample(input logic op, input logic [FieldBits-1:0] emg_a,
                              input logic [FieldBits-1:0] emg_b,
                              input logic [FieldBits-1:0] force_a,
                              input logic [FieldBits-1:0] force_b);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {force_b, force_a, emg_b, emg_a};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      board.note_sample(op, emg_a, emg_b, force_a, force_b);
   endtask

   // Stops offering requests and waits until every queued response is back.
   // At least one edge passes, so the valid is not raised again in this step.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending_status.size() != 0);
   endtask

   // Writes all five registers, then the unused indexes with random data,
   // which the block must ignore. Only called while the block is idle.
   task automatic load_settings(input logic [FieldBits-1:0] base_a,
                                input logic [FieldBits-1:0] base_b,
                                input logic [FieldBits-1:0] open_lim,
                                input logic [FieldBits-1:0] close_lim,
                                input logic [FieldBits-1:0] force_lim);
      logic [FieldBits-1:0] values [CSR_FORCE_THRESHOLD + 1];
      logic [FieldBits-1:0] word;
      values[CSR_BASELINE_FIRST] = base_a;
      values[CSR_BASELINE_SECOND] = base_b;
      values[CSR_OPEN_THRESHOLD] = open_lim;
      values[CSR_CLOSE_THRESHOLD] = close_lim;
      values[CSR_FORCE_THRESHOLD] = force_lim;
      for (int idx = 0; idx < (1 << CsrIndexBits); idx++) begin
         word = (idx <= CSR_FORCE_THRESHOLD) ? values[idx] : FieldBits'($urandom);
         csr_valid <= 1'b1;
         csr_index <= CsrIndexBits'(idx);
         csr_wdata <= word;
         do @(negedge clock); while (!csr_ready);
         @(posedge clock);
         board.write_register(CsrIndexBits'(idx), word);
      end
      csr_valid <= 1'b0;
   endtask

   // A value within spread of center, clipped to the field range.
   function automatic logic [FieldBits-1:0] near(input logic [FieldBits-1:0] center,
                                                 input int spread);
      int v;
      v = int'(center) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > int'(FIELD_MAX)) v = int'(FIELD_MAX);
      return FieldBits'(v);
   endfunction

   // Mostly values up to hi, sometimes the two ends of the field.
   function automatic logic [FieldBits-1:0] pick_value(input int hi);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return FIELD_MAX;
         default: return FieldBits'($urandom_range(0, hi));
      endcase
   endfunction

   // One phase of random requests under one random setting. The EMG samples
   // mostly sit around the baselines with a spread chosen for the phase, and
   // the thresholds are drawn near the levels that spread gives, so the flags
   // keep changing. Forces cluster around their threshold half of the time.
   task automatic run_random_phase(input int phase_no, input int count);
      logic [FieldBits-1:0] base_a, base_b, force_lim;
      logic [FieldBits-1:0] emg_a, emg_b, force_a, force_b;
      logic                 op;
      int                   spread;
      case ($urandom_range(0, 4))
         0: spread = 8;
         1: spread = 64;
         2: spread = 512;
         3: spread = 2048;
         default: spread = int'(FIELD_MAX);
      endcase
      base_a = pick_value(int'(FIELD_MAX));
      base_b = pick_value(int'(FIELD_MAX));
      force_lim = pick_value(int'(FIELD_MAX));
      load_settings(base_a, base_b, pick_value(spread / 2 + 1), pick_value(spread / 2 + 1),
                    force_lim);
      for (int i = 0; i < count; i++) begin
         // A stretch without any idling on either side.
         burst_mode = (i >= 40 && i < 60);
         // Once, the response side stalls for a long time while requests
         // keep coming, so the block fills up and pushes back.
         if (phase_no == 1 && i == 10)
            hold_request = 1'b1;
         // Once, the request side pauses until everything has come back.
         if (phase_no == 2 && i == 50)
            drain_responses();
         op = ($urandom_range(0, 3) == 0) ? OP_CALIBRATION : OP_FULL;
         if ($urandom_range(0, 7) == 0) begin
            emg_a = FieldBits'($urandom);
            emg_b = FieldBits'($urandom);
            force_a = FieldBits'($urandom);
            force_b = FieldBits'($urandom);
         end else begin
            emg_a = near(base_a, spread);
            emg_b = near(base_b, spread);
            force_a = near(force_lim, $urandom_range(0, 1) ? 4 : int'(FIELD_MAX));
            force_b = near(force_lim, $urandom_range(0, 1) ? 4 : int'(FIELD_MAX));
         end
         send_sample(op, emg_a, emg_b, force_a, force_b);
      end
      burst_mode = 1'b0;
      drain_responses();
   endtask

   // Response side: a random stall before each response, none in a burst
   // stretch, and one long stall when asked for.
   initial begin : response_sink
      int          stall;
      logic [55:0] seen;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end else begin
            stall = burst_mode ? 0 : $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         seen = rsp_tdata;
         @(posedge clock);
         board.check_status(seen);
      end
   end

   initial begin : stimulus
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first at the reset settings. The window still holds
      // the zeros left by reset, which count as ordinary samples.
      send_sample(OP_FULL, '0, '0, '0, '0);
      send_sample(OP_FULL, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
      // Calibration request: the forces and flags from above must hold.
      send_sample(OP_CALIBRATION, FIELD_MAX, FIELD_MAX, '0, '0);
      // Forces exactly at and just above the default threshold.
      send_sample(OP_FULL, '0, FIELD_MAX, 12'd512, 12'd513);
      send_sample(OP_FULL, FIELD_MAX, '0, 12'd513, 12'd512);
      send_sample(OP_CALIBRATION, '0, '0, FIELD_MAX, FIELD_MAX);
      send_sample(OP_FULL, 12'hAAA, 12'h555, 12'h555, 12'hAAA);
      send_sample(OP_FULL, 12'h555, 12'hAAA, 12'hAAA, 12'h555);
      drain_responses();

      // Baselines at opposite ends and every threshold at zero.
      load_settings(FIELD_MAX, '0, '0, '0, '0);
      send_sample(OP_FULL, '0, FIELD_MAX, '0, 12'd1);
      send_sample(OP_FULL, FIELD_MAX, '0, 12'd1, '0);
      send_sample(OP_CALIBRATION, 12'd2048, 12'd2048, '0, '0);
      send_sample(OP_FULL, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
      drain_responses();

      // Mid-scale baselines and every threshold at the top of the range.
      load_settings(12'd2048, 12'd2048, FIELD_MAX, FIELD_MAX, FIELD_MAX);
      send_sample(OP_FULL, 12'd2048, 12'd2048, FIELD_MAX, 12'd4094);
      send_sample(OP_FULL, '0, FIELD_MAX, '0, FIELD_MAX);
      send_sample(OP_CALIBRATION, FIELD_MAX, '0, FIELD_MAX, '0);
      send_sample(OP_FULL, 12'd2047, 12'd2049, 12'd4094, FIELD_MAX);
      drain_responses();

      // Random part.
      for (int p = 0; p < 5; p++)
         run_random_phase(p, 100);

      // Everything has come back; give the block time to show any stray
      // response before the verdict.
      drain_responses();
      repeat (2 * RESPONSE_LATENCY) @(posedge clock);
      if (board.mismatches == 0 && board.pending_status.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Ends a run that hangs on a handshake.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule
